// ----- hdl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the ATA PIO read sequencer
// Field widths, command and register codes, task-file offsets, status bits,
// and the job descriptor handed from the front end to the beat generator.
// ----------------------------------------------------------------------------
package aps_pkg;

  // Geometry and field widths
  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned LBA_W            = 28;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned VALUE_W          = 16;
  localparam int unsigned LIMIT_W          = 24;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned PORT_W           = 3;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned PHASE_W          = 3;
  localparam int unsigned STEP_W           = 3;
  localparam int unsigned ISSUE_BEATS      = 6;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPLY = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 1'b1;
  localparam logic [LIMIT_W-1:0]   READ_LIMIT_RST  = 24'd1000000;
  localparam logic [LIMIT_W-1:0]   PROBE_LIMIT_RST = 24'd100000;

  // Bus access kinds
  localparam logic [KIND_W-1:0] BUS_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] BUS_READ  = 2'd1;
  localparam logic [KIND_W-1:0] BUS_WRITE = 2'd2;

  // Task-file register offsets
  localparam logic [PORT_W-1:0] PORT_DATA   = 3'd0;
  localparam logic [PORT_W-1:0] PORT_COUNT  = 3'd2;
  localparam logic [PORT_W-1:0] PORT_LBA0   = 3'd3;
  localparam logic [PORT_W-1:0] PORT_LBA1   = 3'd4;
  localparam logic [PORT_W-1:0] PORT_LBA2   = 3'd5;
  localparam logic [PORT_W-1:0] PORT_DEVICE = 3'd6;
  localparam logic [PORT_W-1:0] PORT_CMD    = 3'd7;

  // Status bits and written bytes
  localparam int unsigned ST_BSY_BIT = 7;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_ERR_BIT = 0;
  localparam logic [BYTE_W-1:0] SECTOR_COUNT_ONE = 8'h01;
  localparam logic [BYTE_W-1:0] DEV_LBA_MODE     = 8'hE0;
  localparam logic [BYTE_W-1:0] ATA_READ_SECTORS = 8'h20;

  // Beats that open a job
  typedef enum logic [1:0] {
    HEAD_NONE,
    HEAD_WORD,
    HEAD_ISSUE
  } head_e;

  // Beat that closes a job
  typedef enum logic [1:0] {
    TAIL_STATUS,
    TAIL_DATA,
    TAIL_DONE_OK,
    TAIL_DONE_FAIL
  } tail_e;

  typedef struct packed {
    head_e                 head;
    tail_e                 tail;
    logic [VALUE_W-1:0]    word_value;
    logic [WORD_IDX_W-1:0] word_pos;
    logic [LBA_W-1:0]      lba;
    logic [COUNT_W-1:0]    head_sector;
    logic [COUNT_W-1:0]    tail_sector;
  } aps_job_t;

  typedef struct packed {
    logic [KIND_W-1:0]     bus_kind;
    logic [PORT_W-1:0]     bus_port;
    logic [BYTE_W-1:0]     bus_wdata;
    logic                  word_valid;
    logic [VALUE_W-1:0]    word_value;
    logic [WORD_IDX_W-1:0] word_position;
    logic [COUNT_W-1:0]    sector_position;
    logic                  done_res;
    logic                  success;
    logic                  last;
  } aps_res_t;

endpackage

// ----- hdl/aps_if.sv -----
// ----------------------------------------------------------------------------
// aps_if: request and result channels of the ATA PIO read sequencer
// Valid/ready channels; a beat moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface aps_req_if import aps_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [LBA_W-1:0]   start_lba;
  logic [COUNT_W-1:0] sector_count;
  logic [VALUE_W-1:0] reply_value;

  modport source (output valid, command, start_lba, sector_count, reply_value,
                  input ready);
  modport sink (input valid, command, start_lba, sector_count, reply_value,
                output ready);
endinterface

interface aps_res_if import aps_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     bus_kind;
  logic [PORT_W-1:0]     bus_port;
  logic [BYTE_W-1:0]     bus_wdata;
  logic                  word_valid;
  logic [VALUE_W-1:0]    word_value;
  logic [WORD_IDX_W-1:0] word_position;
  logic [COUNT_W-1:0]    sector_position;
  logic                  done_res;
  logic                  success;
  logic                  last;

  modport source (output valid, bus_kind, bus_port, bus_wdata, word_valid, word_value,
                  word_position, sector_position, done_res, success, last,
                  input ready);
  modport sink (input valid, bus_kind, bus_port, bus_wdata, word_valid, word_value,
                word_position, sector_position, done_res, success, last,
                output ready);
endinterface

// ----- hdl/ata_pio_sector_read_sequencer.sv -----
// ----------------------------------------------------------------------------
// ata_pio_sector_read_sequencer: host-side ATA PIO LBA28 sector reader
// Turns probe and read requests plus bus replies into task-file accesses
// and delivered data words.
//
// Usage: req_i carries a probe, a read request (start LBA, sector count) or
// the reply to the bus read last issued. res_o carries one beat per bus
// access, delivered data word or completion; last marks the final beat of
// the results caused by one request beat. A request with no results (busy,
// idle reply, unknown command) is simply absorbed.
// Path: an accepted request's job enters the queue, and the beat generator
// loads its first result beat from the queue head into the output register.
// The beat generator emits one result per cycle while res_o.ready is high;
// a request causes 1 to 7 result beats (7 for a sector setup: six register
// writes and a status read). Requests are taken every cycle while the job
// queue between front end and beat generator (QUEUE_DEPTH entries) has room.
// Stall: while res_o.ready is low the output register holds its beat, the
// queue fills and req_i.ready drops only when the queue is full.
// Reset: sequencer idle, queue empty, poll limits at 1000000 (read) and
// 100000 (probe). cfg_we_i writes a limit by index.
// ----------------------------------------------------------------------------
module ata_pio_sector_read_sequencer import aps_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aps_req_if.sink              req_i,
  aps_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  logic     push, q_full, q_valid, pop;
  aps_job_t push_job, head_job;

  // Classify requests
  aps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouple front end and beat generator
  aps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  // Expand jobs into result beats
  aps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .res_o       (res_o)
  );

  // A job is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // Completion always closes the results of a request
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> res_o.last)
    else $error("completion beat not marked last");

  // A data word is never the final beat and carries no bus access
  a_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.word_valid |-> !res_o.last && res_o.bus_kind == BUS_NONE)
    else $error("malformed data word beat");

  // Success is only reported on completion
  a_success_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.success |-> res_o.done_res)
    else $error("success without completion");

endmodule

// ----- hdl/aps_front.sv -----
// ----------------------------------------------------------------------------
// aps_front: request front end
// Accepts requests and bus replies, runs the sequencing state and pushes one
// job descriptor per beat that produces results. Holds the poll limits.
// ----------------------------------------------------------------------------
module aps_front import aps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aps_req_if.sink              req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output aps_job_t             job_o
);

  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PROBE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BUSY  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DRQ   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS_PER_SECTOR - 1);

  logic [LIMIT_W-1:0]    read_lim_q, probe_lim_q;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [LIMIT_W-1:0]    polls_q, polls_d, polls_dec;
  logic [LBA_W-1:0]      lba_q, lba_d;
  logic [COUNT_W-1:0]    left_q, left_d, left_dec;
  logic [COUNT_W-1:0]    sector_q, sector_d;
  logic [WORD_IDX_W-1:0] word_q, word_d;
  logic                  accept;
  logic                  bsy, drq, err;
  logic                  produce;
  aps_job_t              job;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign bsy         = req_i.reply_value[ST_BSY_BIT];
  assign drq         = req_i.reply_value[ST_DRQ_BIT];
  assign err         = req_i.reply_value[ST_ERR_BIT];
  assign polls_dec   = polls_q - LIMIT_W'(1);
  assign left_dec    = left_q - COUNT_W'(1);

  // Hold the poll limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_lim_q  <= READ_LIMIT_RST;
      probe_lim_q <= PROBE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_READ_LIMIT:  read_lim_q  <= cfg_wdata_i;
        CFG_PROBE_LIMIT: probe_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify the beat and advance the sequencing state
  always_comb begin
    phase_d  = phase_q;
    polls_d  = polls_q;
    lba_d    = lba_q;
    left_d   = left_q;
    sector_d = sector_q;
    word_d   = word_q;
    produce  = 1'b0;
    job.head       = HEAD_NONE;
    job.tail       = TAIL_DONE_FAIL;
    job.word_value = req_i.reply_value;
    job.word_pos   = word_q;
    job.lba        = lba_q;

    if (accept) begin
      unique case (req_i.command)
        CMD_PROBE: begin
          if (phase_q == PH_IDLE) begin
            produce  = 1'b1;
            sector_d = '0;
            word_d   = '0;
            if (probe_lim_q != '0) begin
              phase_d  = PH_PROBE;
              polls_d  = probe_lim_q;
              job.tail = TAIL_STATUS;
            end
          end
        end
        CMD_READ: begin
          if (phase_q == PH_IDLE) begin
            produce  = 1'b1;
            lba_d    = req_i.start_lba;
            left_d   = req_i.sector_count;
            sector_d = '0;
            word_d   = '0;
            if (req_i.sector_count != '0 && read_lim_q != '0) begin
              phase_d  = PH_BUSY;
              polls_d  = read_lim_q;
              job.tail = TAIL_STATUS;
            end
          end
        end
        CMD_REPLY: begin
          unique case (phase_q)
            PH_PROBE, PH_BUSY: begin
              produce = 1'b1;
              if (!bsy) begin
                if (phase_q == PH_PROBE) begin
                  phase_d  = PH_IDLE;
                  job.tail = TAIL_DONE_OK;
                end else begin
                  job.head = HEAD_ISSUE;
                  if (read_lim_q != '0) begin
                    phase_d  = PH_DRQ;
                    polls_d  = read_lim_q;
                    job.tail = TAIL_STATUS;
                  end else begin
                    phase_d = PH_IDLE;
                  end
                end
              end else begin
                polls_d = polls_dec;
                if (polls_dec != '0) begin
                  job.tail = TAIL_STATUS;
                end else begin
                  phase_d = PH_IDLE;
                end
              end
            end
            PH_DRQ: begin
              produce = 1'b1;
              if (!bsy && drq) begin
                phase_d  = PH_DATA;
                word_d   = '0;
                job.tail = TAIL_DATA;
              end else if (!bsy && err) begin
                phase_d = PH_IDLE;
              end else begin
                polls_d = polls_dec;
                if (polls_dec != '0) begin
                  job.tail = TAIL_STATUS;
                end else begin
                  phase_d = PH_IDLE;
                end
              end
            end
            PH_DATA: begin
              produce  = 1'b1;
              job.head = HEAD_WORD;
              if (word_q == LAST_WORD) begin
                word_d   = '0;
                sector_d = sector_q + COUNT_W'(1);
                left_d   = left_dec;
                lba_d    = lba_q + LBA_W'(1);
                if (left_dec == '0) begin
                  phase_d  = PH_IDLE;
                  job.tail = TAIL_DONE_OK;
                end else if (read_lim_q != '0) begin
                  phase_d  = PH_BUSY;
                  polls_d  = read_lim_q;
                  job.tail = TAIL_STATUS;
                end else begin
                  phase_d = PH_IDLE;
                end
              end else begin
                word_d   = word_q + WORD_IDX_W'(1);
                job.tail = TAIL_DATA;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    job.head_sector = sector_q;
    job.tail_sector = sector_d;
  end

  // Sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      polls_q  <= '0;
      lba_q    <= '0;
      left_q   <= '0;
      sector_q <= '0;
      word_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      polls_q  <= polls_d;
      lba_q    <= lba_d;
      left_q   <= left_d;
      sector_q <= sector_d;
      word_q   <= word_d;
    end
  end

  assign push_o = produce;
  assign job_o  = job;

endmodule

// ----- hdl/aps_queue.sv -----
// ----------------------------------------------------------------------------
// aps_queue: job queue between front end and beat generator
// Small register FIFO; the head entry is visible to the consumer.
// ----------------------------------------------------------------------------
module aps_queue import aps_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  aps_job_t job_i,
  output logic     full_o,
  output logic     valid_o,
  output aps_job_t job_o,
  input  logic     pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  aps_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/aps_back.sv -----
// ----------------------------------------------------------------------------
// aps_back: beat generator
// Expands each queued job into its result beats, one per cycle, into an
// output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module aps_back import aps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  aps_job_t job_i,
  output logic     pop_o,
  aps_res_if.source res_o
);

  localparam logic [STEP_W-1:0] ISSUE_LAST = STEP_W'(ISSUE_BEATS - 1);

  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  aps_res_t          out_q, beat;
  logic              in_head, load;

  assign in_head = (job_i.head == HEAD_ISSUE && step_q <= ISSUE_LAST) ||
                   (job_i.head == HEAD_WORD && step_q == '0);
  assign load    = job_valid_i && (!out_valid_q || res_o.ready);
  assign pop_o   = load && !in_head;

  // Form the beat at the current step
  always_comb begin
    beat = '0;
    if (in_head) begin
      beat.sector_position = job_i.head_sector;
      if (job_i.head == HEAD_WORD) begin
        beat.word_valid    = 1'b1;
        beat.word_value    = job_i.word_value;
        beat.word_position = job_i.word_pos;
      end else begin
        beat.bus_kind = BUS_WRITE;
        case (step_q)
          3'd0: begin
            beat.bus_port  = PORT_COUNT;
            beat.bus_wdata = SECTOR_COUNT_ONE;
          end
          3'd1: begin
            beat.bus_port  = PORT_LBA0;
            beat.bus_wdata = job_i.lba[7:0];
          end
          3'd2: begin
            beat.bus_port  = PORT_LBA1;
            beat.bus_wdata = job_i.lba[15:8];
          end
          3'd3: begin
            beat.bus_port  = PORT_LBA2;
            beat.bus_wdata = job_i.lba[23:16];
          end
          3'd4: begin
            beat.bus_port  = PORT_DEVICE;
            beat.bus_wdata = DEV_LBA_MODE | {4'b0, job_i.lba[27:24]};
          end
          default: begin
            beat.bus_port  = PORT_CMD;
            beat.bus_wdata = ATA_READ_SECTORS;
          end
        endcase
      end
    end else begin
      beat.sector_position = job_i.tail_sector;
      beat.last            = 1'b1;
      unique case (job_i.tail)
        TAIL_STATUS: begin
          beat.bus_kind = BUS_READ;
          beat.bus_port = PORT_CMD;
        end
        TAIL_DATA: begin
          beat.bus_kind = BUS_READ;
          beat.bus_port = PORT_DATA;
        end
        TAIL_DONE_OK: begin
          beat.done_res = 1'b1;
          beat.success  = 1'b1;
        end
        default: begin
          beat.done_res = 1'b1;
        end
      endcase
    end
  end

  // Advance the step and the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= in_head ? step_q + STEP_W'(1) : '0;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.bus_kind        = out_q.bus_kind;
  assign res_o.bus_port        = out_q.bus_port;
  assign res_o.bus_wdata       = out_q.bus_wdata;
  assign res_o.word_valid      = out_q.word_valid;
  assign res_o.word_value      = out_q.word_value;
  assign res_o.word_position   = out_q.word_position;
  assign res_o.sector_position = out_q.sector_position;
  assign res_o.done_res        = out_q.done_res;
  assign res_o.success         = out_q.success;
  assign res_o.last            = out_q.last;

endmodule

// ----- test/tb_ata_pio_sector_read_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ata_pio_sector_read_sequencer: self-checking bench for the PIO reader
// Feeds probes, sector reads and bus replies through the request channel in
// random bursts. A cycle-free predictor of the sequencer turns every accepted
// request beat into the result beats it must cause, and the monitor checks
// each result beat field by field against the oldest prediction while the
// result side stalls on its own pattern. Poll limits are changed between
// phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_ata_pio_sector_read_sequencer;
  import aps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_PROBE,
    SQ_BUSY,
    SQ_DRQ,
    SQ_DATA
  } seq_phase_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [LBA_W-1:0]   start_lba;
    logic [COUNT_W-1:0] sector_count;
    logic [VALUE_W-1:0] reply_value;
  } req_item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LIMIT_W-1:0]   cfg_wdata_i;

  aps_req_if req_if ();
  aps_res_if res_if ();

  ata_pio_sector_read_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Pending request beats and predicted result beats
  req_item_t pend_q[$];
  aps_res_t  bus_plan_q[$];
  req_item_t drv_item;
  bit        beat_taken = 1'b0;

  int burst_left = 4;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_cnt  = 0;

  int err_cnt       = 0;
  int beats_in      = 0;
  int beats_out     = 0;
  int sent_cnt      = 0;
  int full_sectors  = 0;
  int cfg_writes    = 0;
  int requests_done = 0;

  // Predictor state and its copy of the limit registers
  seq_phase_e         sq_phase        = SQ_IDLE;
  logic [LIMIT_W-1:0] sq_polls_left   = '0;
  logic [LBA_W-1:0]   sq_lba          = '0;
  logic [COUNT_W-1:0] sq_sectors_left = '0;
  logic [COUNT_W-1:0] sq_sector_idx   = '0;
  logic [7:0]         sq_word_idx     = '0;
  logic [LIMIT_W-1:0] lim_read        = READ_LIMIT_RST;
  logic [LIMIT_W-1:0] lim_probe       = PROBE_LIMIT_RST;

  // Limit settings for the random phases, extremes included
  logic [LIMIT_W-1:0] set_read [6] = '{24'd1, 24'd16777215, 24'd3, 24'd2,
                                       24'd16777215, 24'd4};
  logic [LIMIT_W-1:0] set_probe [6] = '{24'd1, 24'd16777215, 24'd2, 24'd16777215,
                                        24'd1, 24'd3};

  // Queue one predicted result beat
  function automatic void push_result(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] port,
                                      logic [BYTE_W-1:0] wdata, logic wv,
                                      logic [VALUE_W-1:0] wval, logic [7:0] wpos,
                                      logic done, logic ok);
    aps_res_t r;
    r.bus_kind        = kind;
    r.bus_port        = port;
    r.bus_wdata       = wdata;
    r.word_valid      = wv;
    r.word_value      = wval;
    r.word_position   = wpos;
    r.sector_position = sq_sector_idx;
    r.done_res        = done;
    r.success         = ok;
    r.last            = 1'b0;
    bus_plan_q.push_back(r);
  endfunction

  function automatic void close_request(logic ok);
    push_result(BUS_NONE, PORT_DATA, '0, 1'b0, '0, '0, 1'b1, ok);
    sq_phase = SQ_IDLE;
    requests_done++;
  endfunction

  // Load the poll allowance and issue the first status read, or fail on a zero limit
  function automatic void open_wait(logic [LIMIT_W-1:0] limit, seq_phase_e nxt);
    sq_polls_left = limit;
    if (limit == '0) begin
      close_request(1'b0);
    end else begin
      sq_phase = nxt;
      push_result(BUS_READ, PORT_CMD, '0, 1'b0, '0, '0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void retry_poll();
    sq_polls_left = sq_polls_left - LIMIT_W'(1);
    if (sq_polls_left == '0) begin
      close_request(1'b0);
    end else begin
      push_result(BUS_READ, PORT_CMD, '0, 1'b0, '0, '0, 1'b0, 1'b0);
    end
  endfunction

  // Advance the predictor by one accepted request beat
  function automatic void predict_beat(req_item_t it);
    int unsigned n0;
    logic [7:0]  st;
    aps_res_t    tail;
    n0 = bus_plan_q.size();
    st = it.reply_value[7:0];
    case (it.command)
      CMD_PROBE: begin
        if (sq_phase == SQ_IDLE) begin
          sq_sector_idx = '0;
          sq_word_idx   = '0;
          open_wait(lim_probe, SQ_PROBE);
        end
      end
      CMD_READ: begin
        if (sq_phase == SQ_IDLE) begin
          sq_lba          = it.start_lba;
          sq_sectors_left = it.sector_count;
          sq_sector_idx   = '0;
          sq_word_idx     = '0;
          if (it.sector_count == '0) close_request(1'b0);
          else open_wait(lim_read, SQ_BUSY);
        end
      end
      CMD_REPLY: begin
        case (sq_phase)
          SQ_PROBE, SQ_BUSY: begin
            if (st[ST_BSY_BIT]) begin
              retry_poll();
            end else if (sq_phase == SQ_PROBE) begin
              close_request(1'b1);
            end else begin
              // Set up one sector and issue the read command
              push_result(BUS_WRITE, PORT_COUNT, SECTOR_COUNT_ONE, 1'b0, '0, '0, 1'b0, 1'b0);
              push_result(BUS_WRITE, PORT_LBA0, sq_lba[7:0], 1'b0, '0, '0, 1'b0, 1'b0);
              push_result(BUS_WRITE, PORT_LBA1, sq_lba[15:8], 1'b0, '0, '0, 1'b0, 1'b0);
              push_result(BUS_WRITE, PORT_LBA2, sq_lba[23:16], 1'b0, '0, '0, 1'b0, 1'b0);
              push_result(BUS_WRITE, PORT_DEVICE, DEV_LBA_MODE | {4'h0, sq_lba[27:24]},
                          1'b0, '0, '0, 1'b0, 1'b0);
              push_result(BUS_WRITE, PORT_CMD, ATA_READ_SECTORS, 1'b0, '0, '0, 1'b0, 1'b0);
              open_wait(lim_read, SQ_DRQ);
            end
          end
          SQ_DRQ: begin
            if (!st[ST_BSY_BIT] && st[ST_DRQ_BIT]) begin
              sq_phase    = SQ_DATA;
              sq_word_idx = '0;
              push_result(BUS_READ, PORT_DATA, '0, 1'b0, '0, '0, 1'b0, 1'b0);
            end else if (!st[ST_BSY_BIT] && st[ST_ERR_BIT]) begin
              close_request(1'b0);
            end else begin
              retry_poll();
            end
          end
          SQ_DATA: begin
            push_result(BUS_NONE, PORT_DATA, '0, 1'b1, it.reply_value, sq_word_idx,
                        1'b0, 1'b0);
            if (sq_word_idx == 8'd255) begin
              // Sector complete: step the address and the count
              sq_word_idx     = '0;
              sq_sector_idx   = sq_sector_idx + COUNT_W'(1);
              sq_sectors_left = sq_sectors_left - COUNT_W'(1);
              sq_lba          = sq_lba + LBA_W'(1);
              if (sq_sectors_left == '0) close_request(1'b1);
              else open_wait(lim_read, SQ_BUSY);
            end else begin
              sq_word_idx = sq_word_idx + 8'd1;
              push_result(BUS_READ, PORT_DATA, '0, 1'b0, '0, '0, 1'b0, 1'b0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Mark the final beat caused by this request
    if (bus_plan_q.size() > n0) begin
      tail      = bus_plan_q.pop_back();
      tail.last = 1'b1;
      bus_plan_q.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Clock and known values on every input from time zero
  initial begin
    clk_i               = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.command      = '0;
    req_if.start_lba    = '0;
    req_if.sector_count = '0;
    req_if.reply_value  = '0;
    res_if.ready        = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: bursts of beats separated by random gaps
  always @(negedge clk_i) begin : drive_req
    req_item_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt      = pend_q.pop_front();
        drv_item = nxt;
        req_if.valid        <= 1'b1;
        req_if.command      <= nxt.command;
        req_if.start_lba    <= nxt.start_lba;
        req_if.sector_count <= nxt.sector_count;
        req_if.reply_value  <= nxt.reply_value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request beat
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      predict_beat(drv_item);
      beat_taken = 1'b1;
      beats_in++;
    end
  end

  // Result ready: switch at random between four stall patterns
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt  = $urandom_range(20, 80);
    end
    stall_cnt--;
    case (stall_mode)
      0:       res_if.ready <= 1'b1;
      1:       res_if.ready <= ($urandom_range(0, 9) < 6);
      2:       res_if.ready <= ((stall_cnt % 4) == 0);
      default: res_if.ready <= ((stall_cnt % 16) >= 10);
    endcase
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i) begin : watch_res
    aps_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beats_out++;
      if (bus_plan_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, actual kind %0d port %0d",
                 $time, res_if.bus_kind, res_if.bus_port);
      end else begin
        want = bus_plan_q.pop_front();
        check_field("bus_kind", 32'(want.bus_kind), 32'(res_if.bus_kind));
        check_field("bus_port", 32'(want.bus_port), 32'(res_if.bus_port));
        check_field("bus_wdata", 32'(want.bus_wdata), 32'(res_if.bus_wdata));
        check_field("word_valid", 32'(want.word_valid), 32'(res_if.word_valid));
        check_field("word_value", 32'(want.word_value), 32'(res_if.word_value));
        check_field("word_position", 32'(want.word_position), 32'(res_if.word_position));
        check_field("sector_position", 32'(want.sector_position),
                    32'(res_if.sector_position));
        check_field("done_res", 32'(want.done_res), 32'(res_if.done_res));
        check_field("success", 32'(want.success), 32'(res_if.success));
        check_field("last", 32'(want.last), 32'(res_if.last));
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [LBA_W-1:0] lba,
                      logic [COUNT_W-1:0] cnt, logic [VALUE_W-1:0] val);
    req_item_t it;
    it.command      = cmd;
    it.start_lba    = lba;
    it.sector_count = cnt;
    it.reply_value  = val;
    pend_q.push_back(it);
    sent_cnt++;
  endtask

  // Reply with a status byte; the unused fields carry noise
  task automatic reply(logic [7:0] st);
    send(CMD_REPLY, LBA_W'($urandom), COUNT_W'($urandom), {8'($urandom), st});
  endtask

  // Hold until every beat is out and every result is in, then close any
  // request still open with error-status replies
  task automatic settle();
    bit open_req;
    open_req = 1'b1;
    while (open_req) begin
      while (pend_q.size() != 0 || req_if.valid || bus_plan_q.size() != 0)
        @(posedge clk_i);
      open_req = (sq_phase != SQ_IDLE);
      if (open_req) send(CMD_REPLY, '0, '0, 16'h0001);
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_READ_LIMIT) lim_read = val;
    else lim_probe = val;
    cfg_writes++;
  endtask

  // Watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    logic [COUNT_W-1:0] cnt;
    logic [LBA_W-1:0]   lba;
    int                 npoll;
    int                 pick;
    int                 start_cnt;

    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Ignored beats, zero count, probe with one busy poll
    send(CMD_REPLY, 28'hFFFFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_UNKNOWN, 28'hFFFFFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_READ, 28'hFFFFFFF, 16'h0000, 16'h0000);
    send(CMD_PROBE, '0, '0, '0);
    reply(8'h80);
    send(CMD_REPLY, '0, '0, 16'hFF7F);
    // Read: busy, ready, DRQ polls with busy and idle status, then error
    send(CMD_READ, 28'h0ABCDEF, 16'd1, '0);
    reply(8'hFF);
    reply(8'h00);
    reply(8'h88);
    reply(8'h81);
    reply(8'h00);
    reply(8'h01);
    // Two-sector read across the address wrap: one full sector, a probe
    // ignored mid-sector, then the second sector set up and failed
    send(CMD_READ, 28'hFFFFFFF, 16'd2, '0);
    reply(8'h80);
    reply(8'h00);
    reply(8'h80);
    reply(8'h48);
    for (int w = 0; w < WORDS_PER_SECTOR; w++) begin
      if (w == 100) send(CMD_PROBE, '0, '0, '0);
      send(CMD_REPLY, LBA_W'($urandom), COUNT_W'($urandom), VALUE_W'($urandom));
    end
    full_sectors++;
    reply(8'h00);
    reply(8'h01);
    settle();

    // Tight limits: timeouts, and requests while busy
    write_limit(CFG_READ_LIMIT, 24'd2);
    write_limit(CFG_PROBE_LIMIT, 24'd1);
    send(CMD_PROBE, '0, '0, '0);
    send(CMD_PROBE, '0, '0, '0);
    send(CMD_READ, 28'h1234567, 16'd3, '0);
    reply(8'h80);
    send(CMD_READ, 28'hFFFFFFF, 16'hFFFF, '0);
    reply(8'h00);
    reply(8'h88);
    reply(8'h02);
    settle();

    // Zero limits fail at once
    write_limit(CFG_READ_LIMIT, 24'd0);
    write_limit(CFG_PROBE_LIMIT, 24'd0);
    send(CMD_PROBE, '0, '0, '0);
    send(CMD_READ, '0, 16'd5, '0);
    reply(8'h00);

    // Random phases, one per limit setting
    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(CFG_READ_LIMIT, set_read[p]);
      write_limit(CFG_PROBE_LIMIT, set_probe[p]);
      start_cnt = sent_cnt;
      while (sent_cnt - start_cnt < 5) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // Probe with a few busy polls
          send(CMD_PROBE, LBA_W'($urandom), COUNT_W'($urandom), VALUE_W'($urandom));
          npoll = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
          for (int i = 0; i < npoll && i < lim_probe; i++) reply(8'($urandom) | 8'h80);
          if (npoll < lim_probe) reply(8'($urandom) & 8'h7F);
        end else if (pick < 22) begin
          send(CMD_READ, LBA_W'($urandom), '0, VALUE_W'($urandom));
        end else if (pick < 30) begin
          // Raw noise, then bring the block back to idle
          repeat ($urandom_range(1, 3))
            send(CMD_W'($urandom_range(0, 3)), LBA_W'($urandom), COUNT_W'($urandom),
                 VALUE_W'($urandom));
          settle();
        end else begin
          // Sector read that fails on a zero count, a timeout or a drive error before data
          cnt = ($urandom_range(0, 9) < 6) ? COUNT_W'($urandom_range(1, 3))
                                           : COUNT_W'($urandom);
          lba = ($urandom_range(0, 3) == 0) ? 28'hFFFFFFF - LBA_W'($urandom_range(0, 2))
                                            : LBA_W'($urandom);
          send(CMD_READ, lba, cnt, VALUE_W'($urandom));
          if (cnt != '0) begin
            npoll = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            for (int i = 0; i < npoll && i < lim_read; i++) reply(8'($urandom) | 8'h80);
            if (npoll < lim_read) begin
              reply(8'($urandom) & 8'h7F);
              npoll = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
              for (int i = 0; i < npoll && i < lim_read; i++)
                reply($urandom_range(0, 1) ? (8'($urandom) | 8'h80) : (8'($urandom) & 8'h76));
              if (npoll < lim_read) reply((8'($urandom) & 8'h76) | 8'h01);
            end
          end
        end
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d request beats, %0d result beats, %0d limit writes",
             beats_in, beats_out, cfg_writes);
    $display("%0d requests finished, %0d sectors read in full", requests_done, full_sectors);
    if (bus_plan_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d predicted result beats never arrived", $time, bus_plan_q.size());
    end
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
